// ----- design/cpu16_instruction_execute_assert.svh -----
// Assertion macros used by the checker file of the executor.
`ifndef CPU16_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CPU16_INSTRUCTION_EXECUTE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define C16IE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define C16IE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/c16ie_pkg.sv -----
package c16ie_pkg;

    typedef logic [15:0] t_word;
    typedef logic [11:0] t_prefix;
    typedef logic [3:0]  t_ridx;

    typedef struct packed {
        logic z;
        logic s;
        logic c;
        logic v;
    } t_flags;

    // Everything one instruction produces: result fields and next state.
    typedef struct packed {
        t_word   next_pc;
        logic    wb_en;
        t_ridx   wb_idx;
        t_word   wb_val;
        t_flags  flags;
        logic    undef;
        t_prefix prefix;
    } t_exec_res;

    // Opcode groups (top nibble of the opcode byte)
    localparam logic [3:0] OpGrpPrefix = 4'h1;
    localparam logic [3:0] OpGrpAluReg = 4'h2;
    localparam logic [3:0] OpGrpAluImm = 4'h3;
    localparam logic [3:0] OpGrpBranch = 4'h4;
    localparam logic [3:0] OpGrpMove   = 4'h5;

    // ALU functions (low nibble of the opcode byte)
    localparam logic [3:0] FnMov   = 4'h0;
    localparam logic [3:0] FnAdd   = 4'h1;
    localparam logic [3:0] FnAdc   = 4'h2;
    localparam logic [3:0] FnSub   = 4'h3;
    localparam logic [3:0] FnSbb   = 4'h4;
    localparam logic [3:0] FnAnd   = 4'h5;
    localparam logic [3:0] FnOr    = 4'h6;
    localparam logic [3:0] FnXor   = 4'h7;
    localparam logic [3:0] FnMul   = 4'h8;
    localparam logic [3:0] FnMulu  = 4'h9;
    localparam logic [3:0] FnRorn  = 4'ha;
    localparam logic [3:0] FnRoln  = 4'hb;
    localparam logic [3:0] FnCmp   = 4'hc;
    localparam logic [3:0] FnTest  = 4'hd;
    localparam logic [3:0] FnUmulu = 4'he;
    localparam logic [3:0] FnBswap = 4'hf;

    // Branch-and-link sits on the last branch code
    localparam logic [3:0] FnLink = 4'hf;

    // Condition codes
    localparam logic [3:0] CondZ   = 4'h0;
    localparam logic [3:0] CondNz  = 4'h1;
    localparam logic [3:0] CondS   = 4'h2;
    localparam logic [3:0] CondNs  = 4'h3;
    localparam logic [3:0] CondC   = 4'h4;
    localparam logic [3:0] CondNc  = 4'h5;
    localparam logic [3:0] CondV   = 4'h6;
    localparam logic [3:0] CondNv  = 4'h7;
    localparam logic [3:0] CondLt  = 4'h8;
    localparam logic [3:0] CondLe  = 4'h9;
    localparam logic [3:0] CondGt  = 4'ha;
    localparam logic [3:0] CondGe  = 4'hb;
    localparam logic [3:0] CondLeu = 4'hc;
    localparam logic [3:0] CondGtu = 4'hd;

    localparam t_ridx LinkReg = 4'd15;
    localparam t_word PcStep  = 16'd2;

    function automatic logic cond_holds(input logic [3:0] code, input t_flags f);
        logic ne;
        logic hit;
        ne = f.v ^ f.s;
        unique case (code)
            CondZ:   hit = f.z;
            CondNz:  hit = !f.z;
            CondS:   hit = f.s;
            CondNs:  hit = !f.s;
            CondC:   hit = f.c;
            CondNc:  hit = !f.c;
            CondV:   hit = f.v;
            CondNv:  hit = !f.v;
            CondLt:  hit = ne;
            CondLe:  hit = f.z || ne;
            CondGt:  hit = !f.z && !ne;
            CondGe:  hit = !ne;
            CondLeu: hit = f.c || f.z;
            CondGtu: hit = !f.c && !f.z;
            default: hit = 1'b1;
        endcase
        return hit;
    endfunction

endpackage

// ----- design/c16ie_if.sv -----
interface c16ie_instr_if;
    import c16ie_pkg::*;
    logic  valid;
    logic  ready;
    t_word instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface c16ie_result_if;
    import c16ie_pkg::*;
    logic  valid;
    logic  ready;
    t_word next_pc;
    logic  wb_enable;
    t_ridx wb_index;
    t_word wb_value;
    logic  flag_zero;
    logic  flag_sign;
    logic  flag_carry;
    logic  flag_overflow;
    logic  undefined_op;

    modport source (output valid, output next_pc, output wb_enable, output wb_index,
                    output wb_value, output flag_zero, output flag_sign,
                    output flag_carry, output flag_overflow, output undefined_op,
                    input ready);
    modport sink   (input valid, input next_pc, input wb_enable, input wb_index,
                    input wb_value, input flag_zero, input flag_sign,
                    input flag_carry, input flag_overflow, input undefined_op,
                    output ready);
endinterface

// ----- design/c16ie_alu.sv -----
module c16ie_alu (
    input  c16ie_pkg::t_word     i_instr_word,
    input  c16ie_pkg::t_word     i_rd_val,
    input  c16ie_pkg::t_word     i_rs_val,
    input  c16ie_pkg::t_word     i_pc,
    input  c16ie_pkg::t_prefix   i_prefix,
    input  c16ie_pkg::t_flags    i_flags,
    output c16ie_pkg::t_exec_res o_res
);
    import c16ie_pkg::*;

    logic [3:0]         grp;
    logic [3:0]         fn;
    t_ridx              rd;
    t_word              imm;
    t_word              opb;
    logic               cin_add;
    logic               cin_sub;
    logic [16:0]        sum17;
    logic [16:0]        bc17;
    logic [16:0]        diff17;
    t_word              logic_res;
    logic               mul_signed;
    logic [16:0]        mul_a;
    logic [16:0]        mul_b;
    logic signed [33:0] prod;
    t_word              pc_inc;
    t_word              br_base;
    t_word              br_target;
    logic               wr_req;
    t_ridx              wr_idx;
    t_word              wr_val;

    assign grp = i_instr_word[15:12];
    assign fn  = i_instr_word[11:8];
    assign rd  = i_instr_word[7:4];
    assign imm = {i_prefix, i_instr_word[3:0]};
    assign opb = (grp == OpGrpAluImm) ? imm : i_rs_val;

    assign cin_add = (fn == FnAdc) & i_flags.c;
    assign cin_sub = (fn == FnSbb) & i_flags.c;
    assign sum17   = {1'b0, i_rd_val} + {1'b0, opb} + {16'b0, cin_add};
    assign bc17    = {1'b0, opb} + {16'b0, cin_sub};
    assign diff17  = {1'b0, i_rd_val} - bc17;

    always_comb begin
        case (fn)
            FnOr:    logic_res = i_rd_val | opb;
            FnXor:   logic_res = i_rd_val ^ opb;
            default: logic_res = i_rd_val & opb;
        endcase
    end

    // One 17x17 signed multiplier covers both signed and unsigned products
    assign mul_signed = (fn == FnMulu);
    assign mul_a      = {mul_signed & i_rd_val[15], i_rd_val};
    assign mul_b      = {mul_signed & opb[15], opb};
    assign prod       = $signed(mul_a) * $signed(mul_b);

    assign pc_inc    = i_pc + PcStep;
    // Link writes r15 before the target read, so r15 as base sees the pc
    assign br_base   = (fn == FnLink && rd == LinkReg) ? i_pc : i_rd_val;
    assign br_target = br_base + imm;

    always_comb begin
        o_res         = '0;
        o_res.next_pc = pc_inc;
        o_res.flags   = i_flags;
        wr_req        = 1'b0;
        wr_idx        = rd;
        wr_val        = '0;

        unique case (grp)
            OpGrpPrefix: begin
                o_res.prefix = i_instr_word[11:0];
            end
            OpGrpAluReg, OpGrpAluImm: begin
                unique case (fn) inside
                    FnMov: begin
                        wr_req = 1'b1;
                        wr_val = opb;
                    end
                    FnAdd, FnAdc: begin
                        o_res.flags.z = (sum17[15:0] == 16'd0);
                        o_res.flags.s = sum17[15];
                        o_res.flags.c = sum17[16];
                        o_res.flags.v = !(i_rd_val[15] ^ opb[15]) & (opb[15] ^ sum17[15]);
                        wr_req = 1'b1;
                        wr_val = sum17[15:0];
                    end
                    FnSub, FnSbb, FnCmp: begin
                        o_res.flags.z = (diff17[15:0] == 16'd0);
                        o_res.flags.s = diff17[15];
                        o_res.flags.c = diff17[16];
                        o_res.flags.v = (i_rd_val[15] ^ opb[15]) & !(opb[15] ^ diff17[15]);
                        wr_req = (fn != FnCmp);
                        wr_val = diff17[15:0];
                    end
                    FnAnd, FnOr, FnXor, FnTest: begin
                        o_res.flags.z = (logic_res == 16'd0);
                        o_res.flags.s = logic_res[15];
                        o_res.flags.c = 1'b0;
                        wr_req = (fn != FnTest);
                        wr_val = logic_res;
                    end
                    FnMul, FnMulu, FnUmulu: begin
                        o_res.flags.z = (prod[15:0] == 16'd0);
                        o_res.flags.s = prod[15];
                        o_res.flags.c = 1'b0;
                        wr_req = 1'b1;
                        wr_val = (fn == FnMul) ? prod[15:0] : prod[31:16];
                    end
                    FnRorn: begin
                        wr_req = 1'b1;
                        wr_val = {opb[3:0], opb[15:4]};
                    end
                    FnRoln: begin
                        wr_req = 1'b1;
                        wr_val = {opb[11:0], opb[15:12]};
                    end
                    FnBswap: begin
                        wr_req = 1'b1;
                        wr_val = {opb[7:0], opb[15:8]};
                    end
                endcase
            end
            OpGrpBranch: begin
                if (fn == FnLink) begin
                    wr_req = 1'b1;
                    wr_idx = LinkReg;
                    wr_val = i_pc;
                end
                if (fn == FnLink || cond_holds(fn, i_flags)) begin
                    o_res.next_pc = br_target;
                end
            end
            OpGrpMove: begin
                wr_req = cond_holds(fn, i_flags);
                wr_val = i_rs_val;
            end
            default: begin
                o_res.undef   = 1'b1;
                o_res.next_pc = i_pc;
                o_res.prefix  = i_prefix;
            end
        endcase

        // r0 is hardwired: writes to it vanish
        if (wr_req && wr_idx != 4'd0) begin
            o_res.wb_en  = 1'b1;
            o_res.wb_idx = wr_idx;
            o_res.wb_val = wr_val;
        end
    end

endmodule

// ----- design/cpu16_instruction_execute.sv -----
// An accepted instruction goes through the input stage and then the result register.
// Throughput: one instruction per cycle; the execute stage (ALU, 17x17 multiplier, flag
//   and pc update) is combinational on operands read as the transaction is taken,
//   so only a result held by the sink stalls the input.
// Reset (synchronous, active low): pc, prefix, flags and both pipeline stages clear;
//   the register file valid bits clear so every register reads as zero at once.
module cpu16_instruction_execute #(
    parameter int unsigned NUM_REGS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    c16ie_instr_if.sink           i_instr,
    c16ie_result_if.source        o_result
);
    import c16ie_pkg::*;

    localparam int unsigned IdxW = $clog2(NUM_REGS);

    // Input stage: instruction word plus the registered register file read data
    logic                 r_in_valid;
    t_word                r_instr;
    t_word                r_rd_val;
    t_word                r_rs_val;

    // Architectural state other than the register file
    t_word                r_pc;
    t_prefix              r_prefix;
    t_flags               r_flags;

    // Register file: a small memory with one valid bit per entry
    t_word                r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  r_mem_vld;

    // Output stage
    logic                 r_out_valid;
    t_exec_res            r_out;

    t_exec_res            exec_res;
    logic                 in_accept;
    logic                 advance;
    logic                 wr_en;
    logic [IdxW-1:0]      wr_idx;
    logic [IdxW-1:0]      rd_addr;
    logic [IdxW-1:0]      rs_addr;

    // Execute whenever an instruction waits and the result register is free
    // or being emptied this cycle.
    assign advance   = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_accept = i_instr.valid && i_instr.ready;
    assign i_instr.ready = !r_in_valid || advance;

    assign wr_en   = advance && exec_res.wb_en;
    assign wr_idx  = IdxW'(exec_res.wb_idx);
    assign rd_addr = IdxW'(i_instr.instr_word[7:4]);
    assign rs_addr = IdxW'(i_instr.instr_word[3:0]);

    c16ie_alu u_alu (
        .i_instr_word (r_instr),
        .i_rd_val     (r_rd_val),
        .i_rs_val     (r_rs_val),
        .i_pc         (r_pc),
        .i_prefix     (r_prefix),
        .i_flags      (r_flags),
        .o_res        (exec_res)
    );

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Read both operands as the transaction is taken. A new transaction is only
    // taken on a cycle where the older one executes (or none is waiting), so the
    // only write that can overtake the read is the one on the same edge: forward it.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_instr <= i_instr.instr_word;
            if (wr_en && wr_idx == rd_addr) begin
                r_rd_val <= exec_res.wb_val;
            end else begin
                r_rd_val <= r_mem_vld[rd_addr] ? r_mem[rd_addr] : '0;
            end
            if (wr_en && wr_idx == rs_addr) begin
                r_rs_val <= exec_res.wb_val;
            end else begin
                r_rs_val <= r_mem_vld[rs_addr] ? r_mem[rs_addr] : '0;
            end
        end
    end

    // Register file write port; r0 is never written so it always reads zero
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= exec_res.wb_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (wr_en) begin
            r_mem_vld[wr_idx] <= 1'b1;
        end
    end

    // Commit pc, prefix and flags as the instruction executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_prefix <= '0;
            r_flags  <= '0;
        end else if (advance) begin
            r_pc     <= exec_res.next_pc;
            r_prefix <= exec_res.prefix;
            r_flags  <= exec_res.flags;
        end
    end

    // Result register: hold until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= exec_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.next_pc       = r_out.next_pc;
    assign o_result.wb_enable     = r_out.wb_en;
    assign o_result.wb_index      = r_out.wb_idx;
    assign o_result.wb_value      = r_out.wb_val;
    assign o_result.flag_zero     = r_out.flags.z;
    assign o_result.flag_sign     = r_out.flags.s;
    assign o_result.flag_carry    = r_out.flags.c;
    assign o_result.flag_overflow = r_out.flags.v;
    assign o_result.undefined_op  = r_out.undef;

endmodule

// ----- design/c16ie_checker.sv -----
`include "cpu16_instruction_execute_assert.svh"

module c16ie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_next_pc,
    input logic        i_wb_enable,
    input logic [3:0]  i_wb_index,
    input logic [15:0] i_wb_value,
    input logic        i_flag_zero,
    input logic        i_flag_sign,
    input logic        i_flag_carry,
    input logic        i_flag_overflow,
    input logic        i_undefined_op
);

    // Leave reset empty and ready
    `C16IE_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (i_in_ready && !i_out_valid), "not idle after reset")

    // Hold a stalled result unchanged
    `C16IE_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_next_pc) && $stable(i_wb_enable) && $stable(i_wb_index) && $stable(i_wb_value) && $stable(i_undefined_op)), "result changed while stalled")

    // Two undefined opcodes in a row keep pc and flags
    `C16IE_ASSERT(a_undef_hold, i_clk, i_rst_n, (i_out_valid && i_out_ready && i_undefined_op) ##1 (i_out_valid && i_undefined_op) |-> (i_next_pc == $past(i_next_pc) && i_flag_zero == $past(i_flag_zero) && i_flag_sign == $past(i_flag_sign) && i_flag_carry == $past(i_flag_carry) && i_flag_overflow == $past(i_flag_overflow)), "undefined opcode changed state")

    // No writeback for undefined opcodes, and never to r0
    `C16IE_ASSERT(a_wb_legal, i_clk, i_rst_n, (i_out_valid && i_wb_enable) |-> (i_wb_index != 4'd0 && !i_undefined_op), "illegal writeback")

endmodule

bind cpu16_instruction_execute c16ie_checker u_c16ie_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_instr.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_next_pc       (o_result.next_pc),
    .i_wb_enable     (o_result.wb_enable),
    .i_wb_index      (o_result.wb_index),
    .i_wb_value      (o_result.wb_value),
    .i_flag_zero     (o_result.flag_zero),
    .i_flag_sign     (o_result.flag_sign),
    .i_flag_carry    (o_result.flag_carry),
    .i_flag_overflow (o_result.flag_overflow),
    .i_undefined_op  (o_result.undefined_op)
);

// ----- dv/cpu16_instruction_execute_tb.sv -----
module cpu16_instruction_execute_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c16ie_pkg::*;

    // Give up well past the slowest legal run: ~1600 transactions, each with
    // random idle gaps on both sides, plus the long hold-off and the pipe.
    localparam int unsigned CycleLimit    = 200000;
    localparam int unsigned HoldoffCycles = 300;
    localparam int unsigned DrainCycles   = 10;

    // What one executed instruction must show on the result channel.
    typedef struct packed {
        t_word  next_pc;
        logic   wb_en;
        t_ridx  wb_idx;
        t_word  wb_val;
        t_flags flags;
        logic   undef;
    } t_instr_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    c16ie_instr_if  instr_if ();
    c16ie_result_if res_if ();

    cpu16_instruction_execute #(
        .NUM_REGS (16)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if),
        .o_result (res_if)
    );

    // Architectural state as the predictor sees it.
    t_word   arch_regs [16];
    t_word   arch_pc;
    t_prefix arch_prefix;
    t_flags  arch_flags;

    t_instr_outcome pending_outcomes [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Idle controls: source gaps, sink stalls, and the long sink hold-off.
    logic src_idle_en     = 1'b0;
    logic sink_idle_en    = 1'b0;
    logic holdoff_request = 1'b0;
    logic holdoff_active  = 1'b0;
    int   sink_gap        = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("FAIL cpu16_instruction_execute");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Flag conditions shared by the branch and the conditional move groups.
    // Codes above the unsigned pair are unconditional.
    function automatic logic condition_met(input logic [3:0] code, input t_flags f);
        logic lt;
        lt = f.s ^ f.v;
        case (code)
            CondZ:   return f.z;
            CondNz:  return ~f.z;
            CondS:   return f.s;
            CondNs:  return ~f.s;
            CondC:   return f.c;
            CondNc:  return ~f.c;
            CondV:   return f.v;
            CondNv:  return ~f.v;
            CondLt:  return lt;
            CondLe:  return lt | f.z;
            CondGt:  return ~lt & ~f.z;
            CondGe:  return ~lt;
            CondLeu: return f.z | f.c;
            CondGtu: return ~(f.z | f.c);
            default: return 1'b1;
        endcase
    endfunction

    // Register write: r0 swallows the value and shows no writeback.
    function automatic void write_reg(input t_ridx idx, input t_word val,
                                      inout t_instr_outcome o);
        if (idx != '0) begin
            arch_regs[idx] = val;
            o.wb_en  = 1'b1;
            o.wb_idx = idx;
            o.wb_val = val;
        end
    endfunction

    // Execute one accepted instruction against the architectural state and
    // queue what the result channel must show for it.
    task automatic execute_instr(input t_word word);
        logic [3:0]     grp;
        logic [3:0]     fn;
        t_ridx          rd;
        t_ridx          rs;
        t_word          imm;
        t_word          a;
        t_word          b;
        logic [31:0]    t;
        t_instr_outcome o;

        grp = word[15:12];
        fn  = word[11:8];
        rd  = word[7:4];
        rs  = word[3:0];
        imm = {arch_prefix, word[3:0]};
        a   = arch_regs[rd];
        o   = '0;
        o.next_pc = arch_pc + PcStep;

        case (grp)
            OpGrpPrefix: begin
                arch_prefix = word[11:0];
            end
            OpGrpAluReg, OpGrpAluImm: begin
                b = (grp == OpGrpAluImm) ? imm : arch_regs[rs];
                arch_prefix = '0;
                case (fn)
                    FnMov: write_reg(rd, b, o);
                    FnAdd, FnAdc: begin
                        t = 32'(a) + 32'(b) + ((fn == FnAdc) ? 32'(arch_flags.c) : 32'd0);
                        arch_flags.z = (t[15:0] == '0);
                        arch_flags.s = t[15];
                        arch_flags.c = t[16];
                        arch_flags.v = ~(a[15] ^ b[15]) & (b[15] ^ t[15]);
                        write_reg(rd, t[15:0], o);
                    end
                    FnSub, FnSbb, FnCmp: begin
                        // Borrow lands in bit 16 of the wide difference.
                        t = 32'(a) - (32'(b) + ((fn == FnSbb) ? 32'(arch_flags.c) : 32'd0));
                        arch_flags.z = (t[15:0] == '0);
                        arch_flags.s = t[15];
                        arch_flags.c = t[16];
                        arch_flags.v = (a[15] ^ b[15]) & ~(b[15] ^ t[15]);
                        if (fn != FnCmp)
                            write_reg(rd, t[15:0], o);
                    end
                    FnAnd, FnOr, FnXor, FnTest: begin
                        if (fn == FnOr)
                            t = 32'(a | b);
                        else if (fn == FnXor)
                            t = 32'(a ^ b);
                        else
                            t = 32'(a & b);
                        arch_flags.z = (t[15:0] == '0);
                        arch_flags.s = t[15];
                        arch_flags.c = 1'b0;
                        if (fn != FnTest)
                            write_reg(rd, t[15:0], o);
                    end
                    FnMul, FnUmulu, FnMulu: begin
                        // Sign-extended operands give the signed product's low 32 bits.
                        if (fn == FnMulu)
                            t = {{16{a[15]}}, a} * {{16{b[15]}}, b};
                        else
                            t = 32'(a) * 32'(b);
                        arch_flags.z = (t[15:0] == '0);
                        arch_flags.s = t[15];
                        arch_flags.c = 1'b0;
                        write_reg(rd, (fn == FnMul) ? t[15:0] : t[31:16], o);
                    end
                    FnRorn:  write_reg(rd, {b[3:0], b[15:4]}, o);
                    FnRoln:  write_reg(rd, {b[11:0], b[15:12]}, o);
                    FnBswap: write_reg(rd, {b[7:0], b[15:8]}, o);
                    default: ;
                endcase
            end
            OpGrpBranch: begin
                // Link goes in first, so a link through r15 targets pc + imm.
                if (fn == FnLink)
                    write_reg(LinkReg, arch_pc, o);
                if (fn == FnLink || condition_met(fn, arch_flags))
                    o.next_pc = arch_regs[rd] + imm;
                arch_prefix = '0;
            end
            OpGrpMove: begin
                if (condition_met(fn, arch_flags))
                    write_reg(rd, arch_regs[rs], o);
                arch_prefix = '0;
            end
            default: begin
                // Undefined: hold the pc, leave all state alone.
                o.undef   = 1'b1;
                o.next_pc = arch_pc;
            end
        endcase

        arch_pc = o.next_pc;
        o.flags = arch_flags;
        pending_outcomes.push_back(o);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input t_word got, input t_word want);
        mismatch_count++;
        $display("%0t mismatch %s: got %h, want %h", $realtime, field, got, want);
    endtask

    task automatic check_field(input string field, input t_word got, input t_word want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // Compare every result transaction with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_instr_outcome want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result, next_pc", res_if.next_pc, '0);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("next_pc", res_if.next_pc, want.next_pc);
                check_field("wb_enable", t_word'(res_if.wb_enable), t_word'(want.wb_en));
                check_field("wb_index", t_word'(res_if.wb_index), t_word'(want.wb_idx));
                check_field("wb_value", res_if.wb_value, want.wb_val);
                check_field("flag_zero", t_word'(res_if.flag_zero), t_word'(want.flags.z));
                check_field("flag_sign", t_word'(res_if.flag_sign), t_word'(want.flags.s));
                check_field("flag_carry", t_word'(res_if.flag_carry),
                            t_word'(want.flags.c));
                check_field("flag_overflow", t_word'(res_if.flag_overflow),
                            t_word'(want.flags.v));
                check_field("undefined_op", t_word'(res_if.undefined_op),
                            t_word'(want.undef));
            end
        end
    end

    // Sink ready: random stall bursts when enabled, and low throughout a
    // hold-off. One update per falling edge.
    always @(negedge i_clk) begin : result_ready_drive
        if (sink_gap != 0)
            sink_gap = sink_gap - 1;
        else if (sink_idle_en && $urandom_range(0, 4) == 0)
            sink_gap = $urandom_range(1, 8);
        res_if.ready <= i_rst_n && !holdoff_active && (sink_gap == 0);
    end

    // Long hold-off on the result side, counted here so the sender keeps
    // offering transactions while the block backs up.
    initial begin : result_holdoff
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                holdoff_active = 1'b1;
                repeat (HoldoffCycles) @(negedge i_clk);
                holdoff_active  = 1'b0;
                holdoff_request = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Instruction side
    // ------------------------------------------------------------------

    function automatic t_word instr(input logic [3:0] grp, input logic [3:0] fn,
                                    input t_ridx rd, input logic [3:0] lo);
        return {grp, fn, rd, lo};
    endfunction

    function automatic t_word prefix_instr(input t_prefix p);
        return {OpGrpPrefix, p};
    endfunction

    // Offer one instruction, hold it until the handshake, then predict it.
    // Valid stays high into the next call unless a gap is drawn.
    task automatic send_instr(input t_word word);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            instr_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        instr_if.valid      <= 1'b1;
        instr_if.instr_word <= word;
        do @(posedge i_clk); while (!instr_if.ready);
        execute_instr(word);
        @(negedge i_clk);
    endtask

    // Mostly defined groups with random fields; a tenth raw words, which
    // are mostly undefined opcodes.
    function automatic t_word pick_instr();
        int unsigned roll;
        logic [3:0]  grp;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            grp = OpGrpPrefix;
        else if (roll < 35)
            grp = OpGrpAluReg;
        else if (roll < 60)
            grp = OpGrpAluImm;
        else if (roll < 75)
            grp = OpGrpBranch;
        else if (roll < 90)
            grp = OpGrpMove;
        else
            return t_word'($urandom);
        return {grp, 12'($urandom)};
    endfunction

    // Random stream; immediate ALU ops often get a fresh prefix ahead of them
    // so that full 16-bit immediates reach the registers.
    task automatic send_random_instrs(input int count);
        t_word word;
        for (int n = 0; n < count; n++) begin
            word = pick_instr();
            if (word[15:12] == OpGrpAluImm && $urandom_range(0, 1) == 0) begin
                send_instr(prefix_instr(t_prefix'($urandom)));
                n++;
            end
            send_instr(word);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_corners();
        send_instr(prefix_instr(12'hfff));                   // prefix all ones
        send_instr(instr(OpGrpAluImm, FnMov, 4'd1, 4'hf));   // r1 = ffff
        send_instr(prefix_instr(12'h800));
        send_instr(instr(OpGrpAluImm, FnMov, 4'd2, 4'h0));   // r2 = 8000
        send_instr(instr(OpGrpAluImm, FnMov, 4'd3, 4'h1));   // prefix cleared: r3 = 1
        send_instr(instr(OpGrpAluReg, FnMov, 4'd4, 4'd1));   // r4 = ffff
        send_instr(instr(OpGrpAluReg, FnAdd, 4'd4, 4'd3));   // wrap to zero with carry
        send_instr(instr(OpGrpAluReg, FnAdc, 4'd4, 4'd3));   // carry in
        send_instr(instr(OpGrpAluReg, FnAdd, 4'd2, 4'd2));   // signed overflow and carry
        send_instr(instr(OpGrpAluReg, FnSub, 4'd5, 4'd3));   // 0 - 1 borrows
        send_instr(instr(OpGrpAluReg, FnSbb, 4'd5, 4'd1));   // borrow in on the full range
        send_instr(instr(OpGrpAluImm, FnMov, 4'd0, 4'h5));   // write to r0 dropped
        send_instr(instr(OpGrpAluReg, FnUmulu, 4'd1, 4'd1)); // high half of ffff * ffff
        send_instr(instr(OpGrpAluReg, FnMulu, 4'd5, 4'd5));  // -1 * -1
        send_instr(instr(OpGrpAluReg, FnMul, 4'd3, 4'd1));
        send_instr(prefix_instr(12'h123));
        send_instr(instr(OpGrpAluImm, FnRorn, 4'd7, 4'h4));  // rotate written back
        send_instr(instr(OpGrpAluReg, FnRoln, 4'd8, 4'd7));
        send_instr(instr(OpGrpAluReg, FnBswap, 4'd9, 4'd7));
        send_instr(instr(OpGrpAluReg, FnCmp, 4'd1, 4'd1));   // equal: Z, no writeback
        send_instr(instr(OpGrpBranch, CondZ, 4'd1, 4'h4));   // taken
        send_instr(instr(OpGrpBranch, CondNz, 4'd1, 4'h4));  // not taken
        send_instr(instr(OpGrpBranch, FnLink, LinkReg, 4'h2)); // link through r15
        send_instr(instr(OpGrpMove, CondNz, 4'd10, 4'd1));   // move not taken
        send_instr(16'h0000);                                // undefined, lowest
        send_instr(16'hffff);                                // undefined, highest
    endtask

    // Bulk random traffic in chunks, each chunk with its own idle mix so
    // that some stretches run with no gaps at all.
    task automatic test_random_mix();
        for (int chunk = 0; chunk < 12; chunk++) begin
            src_idle_en  = ($urandom_range(0, 2) != 0);
            sink_idle_en = ($urandom_range(0, 2) != 0);
            send_random_instrs(100);
        end
    endtask

    // Stop draining results for a long stretch while instructions keep coming.
    task automatic test_output_backpressure();
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        holdoff_request = 1'b1;
        send_random_instrs(80);
        // Drop valid so the last word is not offered again while waiting
        instr_if.valid <= 1'b0;
        while (holdoff_request) @(negedge i_clk);
    endtask

    // Back-to-back tail with no idling on either side.
    task automatic test_full_rate_tail();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_instrs(250);
        instr_if.valid <= 1'b0;
    endtask

    initial begin : run_tests
        for (int i = 0; i < 16; i++)
            arch_regs[i] = '0;
        arch_pc     = '0;
        arch_prefix = '0;
        arch_flags  = '0;

        i_rst_n             = 1'b0;
        instr_if.valid      = 1'b0;
        instr_if.instr_word = '0;
        res_if.ready        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_corners();
        test_random_mix();
        test_output_backpressure();
        test_full_rate_tail();

        // Drain, then run on for DrainCycles so that any stray result shows.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS cpu16_instruction_execute");
        else
            $display("FAIL cpu16_instruction_execute");
        $finish;
    end

endmodule
